@@ hw/rtl/pixel_replication_upscaler_assert.svh @@
// ----------------------------------------------------------------------------
// Pixel replication upscaler assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PIXEL_REPLICATION_UPSCALER_ASSERT_SVH
`define PIXEL_REPLICATION_UPSCALER_ASSERT_SVH

`ifndef SYNTHESIS
`define PRU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pixel_replication_upscaler: assertion failed");
`define PRU_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pixel_replication_upscaler: forbidden condition seen");
`else
`define PRU_ASSERT(label, clk, rst_n, prop)
`define PRU_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

@@ hw/rtl/pru_pkg.sv @@
// ----------------------------------------------------------------------------
// Pixel replication upscaler package
// Shared widths, codes and the run command passed from front to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pru_pkg;

  localparam int PixelW     = 24;
  localparam int ScaleW     = 7;
  localparam int WidthW     = 11;
  localparam int PadW       = 2;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 11;
  localparam int OutDataW   = 40;
  localparam int QueueDepth = 2;

  localparam logic [ScaleW-1:0] ScaleMax = 7'd100;

  localparam logic [CfgIdxW-1:0] CfgScale    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRowWidth = 1'b1;

  localparam logic ModePixel = 1'b0;
  localparam logic ModeTick  = 1'b1;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_REPLAY,
    KIND_REJECT
  } pru_kind_e;

  typedef struct packed {
    pru_kind_e           kind;
    logic [PixelW-1:0]   pixel;
    logic [ScaleW-1:0]   run_length;
    logic                row_end;
    logic [PadW-1:0]     pad;
  } pru_run_t;

endpackage

`default_nettype wire

@@ hw/rtl/pixel_replication_upscaler.sv @@
// ----------------------------------------------------------------------------
// Pixel replication upscaler
// Integer nearest-neighbor upscaler for 24-bit RGB rows with row replay.
// ----------------------------------------------------------------------------
// Takes one item per clock: ready stays high unless output backpressure fills
// the two-entry command queue. Each item makes at most one line-buffer access
// (a write for a source pixel, a read for a replay tick), which sets the rate
// of one item per cycle; each result goes through the command queue and then
// the output register. Source pixels go in with tuser low, replay ticks with
// tuser high; after each source row send scale-1 rows of width ticks. A pixel
// sent during replay comes back with tuser high and zero data. The line buffer
// needs no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module pixel_replication_upscaler #(
  parameter int MAX_ROW_PIXELS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel_in
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [pru_pkg::PixelW-1:0]    s_axis_tdata_i,
  // mode
  input  logic                          s_axis_tuser_i,
  // pixel_out[23:0], run_length[30:24], pad_bytes[32:31], zero[39:33]
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [pru_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // row_end
  output logic                          m_axis_tlast_o,
  // status
  output logic                          m_axis_tuser_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pru_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pru_pkg::CfgDataW-1:0]  cfg_data_i
);
  import pru_pkg::*;

  localparam int ColW  = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
  localparam int QW    = ColW + $bits(pru_run_t);

  logic            push;
  logic [ColW-1:0] push_idx;
  pru_run_t        push_run;
  logic            q_full;
  logic            q_empty;
  logic            pop;
  logic [QW-1:0]   q_data;
  logic [ColW-1:0] q_idx;
  pru_run_t        q_run;

  pru_front #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS),
    .ColW          (ColW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_mode_i  (s_axis_tuser_i),
    .in_pixel_i (s_axis_tdata_i),
    .full_i     (q_full),
    .push_o     (push),
    .push_idx_o (push_idx),
    .push_run_o (push_run)
  );

  pru_queue #(
    .DataW(QW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({push_idx, push_run}),
    .full_o     (q_full),
    .pop_i      (pop),
    .pop_data_o (q_data),
    .empty_o    (q_empty)
  );

  assign q_idx = q_data[QW-1 -: ColW];
  assign q_run = pru_run_t'(q_data[$bits(pru_run_t)-1:0]);

  pru_back #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS),
    .ColW          (ColW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_idx_i    (q_idx),
    .q_run_i    (q_run),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o),
    .out_user_o (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/pru_front.sv @@
// ----------------------------------------------------------------------------
// Pixel replication upscaler front end
// Holds configuration, column and replay count; classifies each item into a
// run command for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pixel_replication_upscaler_assert.svh"

module pru_front #(
  parameter int MAX_ROW_PIXELS = 1024,
  parameter int ColW           = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pru_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pru_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_mode_i,
  input  logic [pru_pkg::PixelW-1:0]    in_pixel_i,
  input  logic                          full_i,
  output logic                          push_o,
  output logic [ColW-1:0]               push_idx_o,
  output pru_pkg::pru_run_t             push_run_o
);
  import pru_pkg::*;

  localparam int WidW = ($clog2(MAX_ROW_PIXELS + 1) > WidthW) ?
                        $clog2(MAX_ROW_PIXELS + 1) : WidthW;

  logic [ScaleW-1:0] scale_q;
  logic [WidthW-1:0] row_width_q;
  logic [ColW-1:0]   column_q, column_d;
  logic [ScaleW-1:0] replays_q, replays_d;

  logic [ScaleW-1:0] s_eff;
  logic [WidW-1:0]   w_eff;
  logic [WidW:0]     col_p1;
  logic              last;
  logic [3:0]        pad_prod;
  logic [PadW-1:0]   pad_row;
  logic              acc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full_i;
  assign acc         = in_valid_i && !full_i;
  assign push_idx_o  = column_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= 7'd1;
      row_width_q <= 11'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgScale:    scale_q     <= cfg_data_i[ScaleW-1:0];
        CfgRowWidth: row_width_q <= cfg_data_i[WidthW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (scale_q == '0) begin
      s_eff = ScaleW'(1);
    end else if (scale_q > ScaleMax) begin
      s_eff = ScaleMax;
    end else begin
      s_eff = scale_q;
    end
  end

  always_comb begin
    priority if (row_width_q == '0) begin
      w_eff = WidW'(1);
    end else if (WidW'(row_width_q) > WidW'(MAX_ROW_PIXELS)) begin
      w_eff = WidW'(MAX_ROW_PIXELS);
    end else begin
      w_eff = WidW'(row_width_q);
    end
  end

  assign col_p1   = (WidW + 1)'(column_q) + (WidW + 1)'(1);
  assign last     = col_p1 >= {1'b0, w_eff};
  assign pad_prod = {2'b00, w_eff[1:0]} * {2'b00, s_eff[1:0]};
  assign pad_row  = pad_prod[PadW-1:0];

  always_comb begin
    push_o     = 1'b0;
    push_run_o = '{kind: KIND_REJECT, pixel: '0, run_length: '0, row_end: 1'b0, pad: '0};
    column_d   = column_q;
    replays_d  = replays_q;
    if (acc) begin
      if (in_mode_i == ModePixel) begin
        push_o = 1'b1;
        if (replays_q == '0) begin
          push_run_o.kind       = KIND_PIXEL;
          push_run_o.pixel      = in_pixel_i;
          push_run_o.run_length = s_eff;
          push_run_o.row_end    = last;
          push_run_o.pad        = last ? pad_row : '0;
          column_d              = last ? '0 : col_p1[ColW-1:0];
          if (last) begin
            replays_d = s_eff - ScaleW'(1);
          end
        end
      end else if (replays_q != '0) begin
        push_o                = 1'b1;
        push_run_o.kind       = KIND_REPLAY;
        push_run_o.run_length = s_eff;
        push_run_o.row_end    = last;
        push_run_o.pad        = last ? pad_row : '0;
        column_d              = last ? '0 : col_p1[ColW-1:0];
        if (last) begin
          replays_d = replays_q - ScaleW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q  <= '0;
      replays_q <= '0;
    end else begin
      column_q  <= column_d;
      replays_q <= replays_d;
    end
  end

  `PRU_ASSERT(a_replays_bound, clk_i, rst_ni, replays_q <= ScaleMax - ScaleW'(1))
  `PRU_ASSERT(a_idle_tick_drop, clk_i, rst_ni,
              (acc && in_mode_i == ModeTick && replays_q == '0) |-> !push_o)
  `PRU_ASSERT(a_reject_keeps_state, clk_i, rst_ni,
              (acc && in_mode_i == ModePixel && replays_q != '0) |=>
              ($stable(replays_q) && $stable(column_q)))

endmodule

`default_nettype wire

@@ hw/rtl/pru_queue.sv @@
// ----------------------------------------------------------------------------
// Pixel replication upscaler command queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pru_queue #(
  parameter int DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [DataW-1:0] pop_data_o,
  output logic             empty_o
);
  import pru_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  logic [DataW-1:0] store_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o     = cnt_q == CntW'(QueueDepth);
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pru_back.sv @@
// ----------------------------------------------------------------------------
// Pixel replication upscaler back end
// Executes run commands against the line buffer and drives the output item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pru_back #(
  parameter int MAX_ROW_PIXELS = 1024,
  parameter int ColW           = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  logic [ColW-1:0]                q_idx_i,
  input  pru_pkg::pru_run_t              q_run_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pru_pkg::OutDataW-1:0]   out_data_o,
  output logic                           out_last_o,
  output logic                           out_user_o
);
  import pru_pkg::*;

  logic [PixelW-1:0] line_store [MAX_ROW_PIXELS];
  logic              vld_q, vld_d;
  pru_run_t          run_q;
  logic [PixelW-1:0] rd_q;
  logic [PixelW-1:0] pix_out;

  assign pop_o = !q_empty_i && (!vld_q || out_ready_i);

  always_comb begin
    vld_d = vld_q;
    if (pop_o) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      run_q <= q_run_i;
      if (q_run_i.kind == KIND_PIXEL) begin
        line_store[q_idx_i] <= q_run_i.pixel;
      end
      if (q_run_i.kind == KIND_REPLAY) begin
        rd_q <= line_store[q_idx_i];
      end
    end
  end

  assign pix_out     = (run_q.kind == KIND_REPLAY) ? rd_q : run_q.pixel;
  assign out_valid_o = vld_q;
  assign out_data_o  = {7'b0, run_q.pad, run_q.run_length, pix_out};
  assign out_last_o  = run_q.row_end;
  assign out_user_o  = run_q.kind == KIND_REJECT;

endmodule

`default_nettype wire
